// ===== src/xs_pkg.sv =====
// shared types and constants for the xoshiro128** word generator
package xs_pkg;

   localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
   localparam logic [31:0] MIX_MULT    = 32'h045d_9f3b;

   localparam logic ACTION_SEED = 1'b0;
   localparam logic ACTION_NEXT = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load_seed;
      logic       add_golden;
      logic       mix_from_acc;
      logic       mix_from_z;
      logic       store_word;
      logic       next_word;
      logic [1:0] round;
   } cmd_type;

endpackage

// ===== src/xs_datapath.sv =====
// datapath: seed expansion registers, shared mix multiplier, generator state, result register
module xs_datapath
   import xs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [31:0] seed,
   input  logic [2:0]  byte_count,
   output logic [31:0] random_word,
   output logic [2:0]  bytes_valid
);

   logic [31:0] acc_ff, acc_in;
   logic [31:0] z_ff, z_in;
   logic [31:0] gen_ff [4];
   logic [31:0] gen_in [4];
   logic [31:0] word_ff, word_in;
   logic [2:0]  count_ff, count_in;

   logic [31:0] mix_src;
   logic [31:0] mix_xor;
   logic [31:0] mix_prod;
   logic [31:0] s1_times5;
   logic [31:0] s1_rot;
   logic [31:0] raw_word;
   logic [2:0]  count_sat;
   logic [31:0] mask;
   logic [31:0] s2_x;
   logic [31:0] s3_x;

   // one shared multiplier, registered into z_ff
   assign mix_src  = cmd.mix_from_acc ? acc_ff : z_ff;
   assign mix_xor  = mix_src ^ (mix_src >> 16);
   assign mix_prod = mix_xor * MIX_MULT;

   // rotl(s1 * 5, 7) * 9 with shift-adds
   assign s1_times5 = gen_ff[1] + (gen_ff[1] << 2);
   assign s1_rot    = {s1_times5[24:0], s1_times5[31:25]};
   assign raw_word  = s1_rot + (s1_rot << 3);

   assign s2_x = gen_ff[2] ^ gen_ff[0];
   assign s3_x = gen_ff[3] ^ gen_ff[1];

   always_comb begin
      if (byte_count == 3'd0) begin
         count_sat = 3'd1;
      end else if (byte_count > 3'd4) begin
         count_sat = 3'd4;
      end else begin
         count_sat = byte_count;
      end
   end

   always_comb begin
      case (count_sat)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      acc_in   = acc_ff;
      z_in     = z_ff;
      word_in  = word_ff;
      count_in = count_ff;
      for (int i = 0; i < 4; i++) begin
         gen_in[i] = gen_ff[i];
      end
      if (cmd.load_seed) begin
         acc_in = seed + GOLDEN_STEP;
      end
      if (cmd.add_golden) begin
         acc_in = acc_ff + GOLDEN_STEP;
      end
      if (cmd.mix_from_acc || cmd.mix_from_z) begin
         z_in = mix_prod;
      end
      if (cmd.store_word) begin
         gen_in[cmd.round] = z_ff ^ (z_ff >> 16);
      end
      if (cmd.next_word) begin
         word_in   = raw_word & mask;
         count_in  = count_sat;
         gen_in[0] = gen_ff[0] ^ s3_x;
         gen_in[1] = gen_ff[1] ^ s2_x;
         gen_in[2] = s2_x ^ (gen_ff[1] << 9);
         gen_in[3] = {s3_x[20:0], s3_x[31:21]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            gen_ff[i] <= '0;
         end
      end else begin
         acc_ff <= acc_in;
         for (int i = 0; i < 4; i++) begin
            gen_ff[i] <= gen_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      word_ff  <= word_in;
      count_ff <= count_in;
   end

   assign random_word = word_ff;
   assign bytes_valid = count_ff;

endmodule

// ===== src/xs_controller.sv =====
// controller: request handshake, seed expansion sequencer, result valid flag
module xs_controller
   import xs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_action,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_MIX1  = 5'b00100,
      ST_MIX2  = 5'b01000,
      ST_STORE = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      cmd      = '0;
      cmd.round = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_action == ACTION_SEED) begin
               cmd.load_seed = 1'b1;
               round_in      = 2'd0;
               state_in      = ST_MIX1;
            end else if (accept) begin
               cmd.next_word = 1'b1;
            end
         end
         ST_ADD: begin
            cmd.add_golden = 1'b1;
            state_in       = ST_MIX1;
         end
         ST_MIX1: begin
            cmd.mix_from_acc = 1'b1;
            state_in         = ST_MIX2;
         end
         ST_MIX2: begin
            cmd.mix_from_z = 1'b1;
            state_in       = ST_STORE;
         end
         ST_STORE: begin
            cmd.store_word = 1'b1;
            // round wraps back to zero after the fourth word
            round_in       = round_ff + 2'd1;
            state_in       = (round_ff == 2'd3) ? ST_IDLE : ST_ADD;
         end
         default: begin
            state_in = ST_IDLE;
            round_in = 2'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_action == ACTION_NEXT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_seed_blocks: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACTION_SEED |=> !req_tready)
      else $error("request taken right after a seed transfer");

   a_next_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACTION_NEXT |=> rsp_tvalid)
      else $error("next transfer did not raise a result");

   a_idle_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> round_ff == 2'd0)
      else $error("round counter not cleared in idle");

   a_last_store: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE && round_ff == 2'd3 |=> state_ff == ST_IDLE)
      else $error("seed expansion did not end after fourth word");

endmodule

// ===== src/xoshiro128ss_word_generator_top.sv =====
// top level of the xoshiro128** word generator
// On a next request (tuser = 1) the word is computed from the current state,
// registered, and shown on the result channel the next cycle while the state
// advances, so next requests stream at one per cycle as long as results are
// taken. A seed request (tuser = 0) gives no result and keeps the request side
// busy after its transfer while the four state words are mixed one after another
// through a single shared 32x32 multiplier, two passes per word, with an add and
// a store step around them. Before the first seed the state is all zero and every
// word is zero. Byte counts of zero read as one, above four as four.
module xoshiro128ss_word_generator_top
   import xs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // seed [31:0], byte_count [34:32], zero [39:35]
   input  logic        req_tuser,   // action [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // random_word [31:0], bytes_valid [34:32], zero [39:35]
);

   cmd_type     cmd;
   logic [31:0] random_word;
   logic [2:0]  bytes_valid;

   xs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   xs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .seed        (req_tdata[31:0]),
      .byte_count  (req_tdata[34:32]),
      .random_word (random_word),
      .bytes_valid (bytes_valid)
   );

   assign rsp_tdata = {5'd0, bytes_valid, random_word};

endmodule
